// ===== hdl/gpio_irq_pkg.sv =====
// Types and codes shared by the GPIO port block with edge interrupts.
// No dependencies; compile before the interfaces and modules.
`default_nettype none

package gpio_irq_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BOARD_IO_W = 7;
  localparam int unsigned PIN_W   = 5;
  localparam int unsigned REG_W   = 3;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_DRIVE_MF = 2'd2,
    OP_DRIVE_IO = 2'd3
  } op_t;

  typedef enum logic [REG_W-1:0] {
    REG_CTL     = 3'd0,
    REG_MFDOUT  = 3'd1,
    REG_MFDIR   = 3'd2,
    REG_MFDIN   = 3'd3,
    REG_MFSEL   = 3'd4,
    REG_IOPD    = 3'd5,
    REG_MFPD    = 3'd6,
    REG_INVALID = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    IRQ_MF_RISE = 2'd0,
    IRQ_MF_FALL = 2'd1,
    IRQ_IO      = 2'd2
  } irq_group_t;

  localparam int unsigned CTL_DBS_SHIFT = 24;
  localparam int unsigned CTL_DIR_SHIFT = 16;
  localparam int unsigned CTL_OUT_SHIFT = 8;
  localparam int unsigned IO_RISE_SHIFT = 7;

  typedef struct packed {
    op_t                   operation;
    reg_idx_t              reg_index;
    logic [WORD_W-1:0]     write_data;
    logic [PIN_W-1:0]      pin_number;
    logic                  pin_level;
    logic [BOARD_IO_W-1:0] board_io_levels;
    logic [WORD_W-1:0]     board_mf_levels;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]     read_data;
    logic                  access_error;
    logic                  irq_valid;
    irq_group_t            irq_group;
    logic [WORD_W-1:0]     irq_bits;
    logic                  outputs_changed;
    logic [BOARD_IO_W-1:0] io_out_levels;
    logic [BOARD_IO_W-1:0] io_out_enable;
    logic [WORD_W-1:0]     mf_out_levels;
    logic [WORD_W-1:0]     mf_out_enable;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/gpio_irq_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on gpio_irq_pkg.
`default_nettype none

interface gpio_irq_req_if import gpio_irq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [REG_W-1:0]      reg_index;
  logic [WORD_W-1:0]     write_data;
  logic [PIN_W-1:0]      pin_number;
  logic                  pin_level;
  logic [BOARD_IO_W-1:0] board_io_levels;
  logic [WORD_W-1:0]     board_mf_levels;

  modport source (output valid, operation, reg_index, write_data, pin_number, pin_level,
                  board_io_levels, board_mf_levels, input ready);
  modport sink (input valid, operation, reg_index, write_data, pin_number, pin_level,
                board_io_levels, board_mf_levels, output ready);
endinterface

interface gpio_irq_rsp_if import gpio_irq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WORD_W-1:0]     read_data;
  logic                  access_error;
  logic                  irq_valid;
  logic [1:0]            irq_group;
  logic [WORD_W-1:0]     irq_bits;
  logic                  outputs_changed;
  logic [BOARD_IO_W-1:0] io_out_levels;
  logic [BOARD_IO_W-1:0] io_out_enable;
  logic [WORD_W-1:0]     mf_out_levels;
  logic [WORD_W-1:0]     mf_out_enable;

  modport source (output valid, read_data, access_error, irq_valid, irq_group, irq_bits,
                  outputs_changed, io_out_levels, io_out_enable, mf_out_levels,
                  mf_out_enable, input ready);
  modport sink (input valid, read_data, access_error, irq_valid, irq_group, irq_bits,
                outputs_changed, io_out_levels, io_out_enable, mf_out_levels,
                mf_out_enable, output ready);
endinterface

`default_nettype wire

// ===== hdl/gpio_irq_regs.sv =====
// Register file, read mux, pin-drive latches and edge detection of the GPIO port.
// Depends on gpio_irq_pkg. State advances on commit; result is combinational.
`default_nettype none

module gpio_irq_regs import gpio_irq_pkg::*; #(
  parameter int unsigned IO_PINS = 7,
  parameter int unsigned MF_PINS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic commit,
  input  wire req_t req,
  output rsp_t      rsp
);

  localparam logic [WORD_W-1:0] IO_MASK = WORD_W'((64'd1 << IO_PINS) - 64'd1);
  localparam logic [WORD_W-1:0] MF_MASK = WORD_W'((64'd1 << MF_PINS) - 64'd1);
  localparam logic [WORD_W-1:0] CTL_WRITABLE = (IO_MASK << CTL_DBS_SHIFT)
                                             | (IO_MASK << CTL_DIR_SHIFT)
                                             | (IO_MASK << CTL_OUT_SHIFT);
  localparam logic [WORD_W-1:0] CTL_RESERVED = ~(CTL_WRITABLE | IO_MASK);

  logic [IO_PINS-1:0] ctl_dbs, ctl_dbs_next;
  logic [IO_PINS-1:0] ctl_dir, ctl_dir_next;
  logic [IO_PINS-1:0] ctl_out, ctl_out_next;
  logic [MF_PINS-1:0] mf_output_data, mf_output_data_next;
  logic [MF_PINS-1:0] mf_direction, mf_direction_next;
  logic [MF_PINS-1:0] mf_select, mf_select_next;
  logic [IO_PINS-1:0] io_powerdown, io_powerdown_next;
  logic [MF_PINS-1:0] mf_powerdown, mf_powerdown_next;
  logic [MF_PINS-1:0] mf_driven_levels, mf_driven_levels_next;
  logic [IO_PINS-1:0] io_driven_levels, io_driven_levels_next;

  logic [WORD_W-1:0]  ctl_word;
  logic [IO_PINS-1:0] io_din;
  logic [MF_PINS-1:0] mf_outs;
  logic [MF_PINS-1:0] mf_din;
  logic [MF_PINS-1:0] mf_bit;
  logic [IO_PINS-1:0] io_bit;
  logic               mf_pin_ok;
  logic               io_pin_ok;
  logic               mf_old;
  logic               io_old;

  assign ctl_word = (WORD_W'(ctl_dbs) << CTL_DBS_SHIFT)
                  | (WORD_W'(ctl_dir) << CTL_DIR_SHIFT)
                  | (WORD_W'(ctl_out) << CTL_OUT_SHIFT);
  assign io_din   = (ctl_out & ctl_dir)
                  | ((io_driven_levels | IO_PINS'(req.board_io_levels)) & ~ctl_dir);
  assign mf_outs  = mf_direction & mf_select;
  assign mf_din   = (mf_output_data & mf_outs)
                  | ((mf_driven_levels | MF_PINS'(req.board_mf_levels)) & ~mf_outs);

  assign mf_bit    = MF_PINS'(1) << req.pin_number;
  assign io_bit    = IO_PINS'(1) << req.pin_number;
  assign mf_pin_ok = 6'(req.pin_number) < 6'(MF_PINS);
  assign io_pin_ok = 6'(req.pin_number) < 6'(IO_PINS);
  assign mf_old    = |(mf_driven_levels & mf_bit);
  assign io_old    = |(io_driven_levels & io_bit);

  always_comb begin
    ctl_dbs_next          = ctl_dbs;
    ctl_dir_next          = ctl_dir;
    ctl_out_next          = ctl_out;
    mf_output_data_next   = mf_output_data;
    mf_direction_next     = mf_direction;
    mf_select_next        = mf_select;
    io_powerdown_next     = io_powerdown;
    mf_powerdown_next     = mf_powerdown;
    mf_driven_levels_next = mf_driven_levels;
    io_driven_levels_next = io_driven_levels;
    rsp                   = '0;

    unique case (req.operation)
      OP_READ: begin
        unique case (req.reg_index)
          REG_CTL:    rsp.read_data = ctl_word | WORD_W'(io_din);
          REG_MFDOUT: rsp.read_data = WORD_W'(mf_output_data);
          REG_MFDIR:  rsp.read_data = WORD_W'(mf_direction);
          REG_MFDIN:  rsp.read_data = WORD_W'(mf_din);
          REG_MFSEL:  rsp.read_data = WORD_W'(mf_select);
          REG_IOPD:   rsp.read_data = WORD_W'(io_powerdown);
          REG_MFPD:   rsp.read_data = WORD_W'(mf_powerdown);
          default:    rsp.access_error = 1'b1;
        endcase
      end
      OP_WRITE: begin
        unique case (req.reg_index)
          REG_CTL: begin
            if ((req.write_data & CTL_RESERVED) != '0) begin
              rsp.access_error = 1'b1;
            end else begin
              ctl_dbs_next        = IO_PINS'(req.write_data >> CTL_DBS_SHIFT);
              ctl_dir_next        = IO_PINS'(req.write_data >> CTL_DIR_SHIFT);
              ctl_out_next        = IO_PINS'(req.write_data >> CTL_OUT_SHIFT);
              rsp.outputs_changed = 1'b1;
            end
          end
          REG_MFDOUT: begin
            mf_output_data_next = MF_PINS'(req.write_data & MF_MASK);
            rsp.outputs_changed = 1'b1;
          end
          REG_MFDIR: begin
            mf_direction_next   = MF_PINS'(req.write_data & MF_MASK);
            rsp.outputs_changed = 1'b1;
          end
          REG_MFSEL: begin
            mf_select_next      = MF_PINS'(req.write_data & MF_MASK);
            rsp.outputs_changed = 1'b1;
          end
          REG_IOPD: begin
            if ((req.write_data & ~IO_MASK) != '0) begin
              rsp.access_error = 1'b1;
            end else begin
              io_powerdown_next = IO_PINS'(req.write_data);
            end
          end
          REG_MFPD: mf_powerdown_next = MF_PINS'(req.write_data & MF_MASK);
          default:  rsp.access_error = 1'b1;
        endcase
      end
      OP_DRIVE_MF: begin
        if (!mf_pin_ok) begin
          rsp.access_error = 1'b1;
        end else begin
          mf_driven_levels_next = req.pin_level ? (mf_driven_levels | mf_bit)
                                                : (mf_driven_levels & ~mf_bit);
          if (mf_old != req.pin_level) begin
            rsp.irq_valid = 1'b1;
            rsp.irq_group = req.pin_level ? IRQ_MF_RISE : IRQ_MF_FALL;
            rsp.irq_bits  = WORD_W'(mf_bit);
          end
        end
      end
      default: begin
        if (!io_pin_ok) begin
          rsp.access_error = 1'b1;
        end else begin
          io_driven_levels_next = req.pin_level ? (io_driven_levels | io_bit)
                                                : (io_driven_levels & ~io_bit);
          if (io_old != req.pin_level) begin
            rsp.irq_valid = 1'b1;
            rsp.irq_group = IRQ_IO;
            rsp.irq_bits  = req.pin_level
                          ? (WORD_W'(1) << (6'(req.pin_number) + 6'(IO_RISE_SHIFT)))
                          : (WORD_W'(1) << req.pin_number);
          end
        end
      end
    endcase

    rsp.io_out_levels = BOARD_IO_W'(ctl_out_next);
    rsp.io_out_enable = BOARD_IO_W'(ctl_dir_next);
    rsp.mf_out_levels = WORD_W'(mf_output_data_next);
    rsp.mf_out_enable = WORD_W'(mf_direction_next & mf_select_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_dbs          <= '0;
      ctl_dir          <= '0;
      ctl_out          <= '0;
      mf_output_data   <= '0;
      mf_direction     <= '0;
      mf_select        <= '0;
      io_powerdown     <= '0;
      mf_powerdown     <= '0;
      mf_driven_levels <= '0;
      io_driven_levels <= '0;
    end else if (commit) begin
      ctl_dbs          <= ctl_dbs_next;
      ctl_dir          <= ctl_dir_next;
      ctl_out          <= ctl_out_next;
      mf_output_data   <= mf_output_data_next;
      mf_direction     <= mf_direction_next;
      mf_select        <= mf_select_next;
      io_powerdown     <= io_powerdown_next;
      mf_powerdown     <= mf_powerdown_next;
      mf_driven_levels <= mf_driven_levels_next;
      io_driven_levels <= io_driven_levels_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gpio_port_registers_edge_irq.sv =====
// Top level of the GPIO port with edge interrupts: input register, result register.
// Depends on gpio_irq_pkg, gpio_irq_if and gpio_irq_regs.
//
//   channel | modport | beat
//   --------+---------+------------------------------------------------
//   req     | sink    | one bus access or pin-drive event
//   rsp     | source  | read data, error, interrupt mask, output levels
//
// One beat per cycle sustained while rsp is ready. An accepted req is held in the input
// register, which feeds the register file; its update and the result capture share one
// edge. A waiting result stalls the input register, and req stays ready while that
// register can drain. Synchronous reset clears all pin and register state and empties
// both stages.
`default_nettype none

module gpio_port_registers_edge_irq import gpio_irq_pkg::*; #(
  parameter int unsigned IO_PINS = 7,
  parameter int unsigned MF_PINS = 32
) (
  input wire logic      clk,
  input wire logic      rst,
  gpio_irq_req_if.sink   req,
  gpio_irq_rsp_if.source rsp
);

  logic req_valid;
  req_t req_q;
  logic rsp_valid;
  rsp_t rsp_q;
  rsp_t rsp_next;
  logic advance;

  assign advance   = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !req_valid || advance;

  gpio_irq_regs #(
    .IO_PINS (IO_PINS),
    .MF_PINS (MF_PINS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .req    (req_q),
    .rsp    (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.operation       <= op_t'(req.operation);
      req_q.reg_index       <= reg_idx_t'(req.reg_index);
      req_q.write_data      <= req.write_data;
      req_q.pin_number      <= req.pin_number;
      req_q.pin_level       <= req.pin_level;
      req_q.board_io_levels <= req.board_io_levels;
      req_q.board_mf_levels <= req.board_mf_levels;
    end
    if (advance) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.read_data       = rsp_q.read_data;
  assign rsp.access_error    = rsp_q.access_error;
  assign rsp.irq_valid       = rsp_q.irq_valid;
  assign rsp.irq_group       = rsp_q.irq_group;
  assign rsp.irq_bits        = rsp_q.irq_bits;
  assign rsp.outputs_changed = rsp_q.outputs_changed;
  assign rsp.io_out_levels   = rsp_q.io_out_levels;
  assign rsp.io_out_enable   = rsp_q.io_out_enable;
  assign rsp.mf_out_levels   = rsp_q.mf_out_levels;
  assign rsp.mf_out_enable   = rsp_q.mf_out_enable;

endmodule

`default_nettype wire

// ===== sim/tb_gpio_port_registers_edge_irq.sv =====
// Self-checking testbench for gpio_port_registers_edge_irq: register reads and writes,
// pin-drive edges and interrupt masks, checked beat by beat against an in-bench predictor.
// Depends on gpio_irq_pkg, gpio_irq_if and the RTL of the block.
`default_nettype none

module tb_gpio_port_registers_edge_irq;
  import gpio_irq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IO_PINS     = 7;
  localparam int unsigned MF_PINS     = 32;
  localparam logic [31:0] IO_MASK     = (32'd1 << IO_PINS) - 32'd1;
  localparam logic [31:0] CTL_WRITABLE =
      (IO_MASK << CTL_DBS_SHIFT) | (IO_MASK << CTL_DIR_SHIFT) | (IO_MASK << CTL_OUT_SHIFT);
  localparam logic [31:0] CTL_RESERVED = ~(CTL_WRITABLE | IO_MASK);
  localparam int unsigned HOLD_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gpio_irq_req_if req_ch ();
  gpio_irq_rsp_if rsp_ch ();

  gpio_port_registers_edge_irq #(
    .IO_PINS(IO_PINS),
    .MF_PINS(MF_PINS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted port state
  logic [31:0] ctl_word;
  logic [31:0] mf_dout;
  logic [31:0] mf_dir;
  logic [31:0] mf_sel;
  logic [6:0]  io_pd;
  logic [31:0] mf_pd;
  logic [31:0] mf_latched;
  logic [6:0]  io_latched;

  rsp_t        pending_q[$];
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;
  int unsigned results_checked = 0;
  int unsigned irq_count = 0;
  int unsigned error_count = 0;
  int unsigned changed_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_requests = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;

  function automatic rsp_t gpio_predict(input req_t b);
    rsp_t        r;
    logic [6:0]  dir;
    logic [6:0]  din;
    logic [31:0] outs;
    logic        prev;
    r = '0;
    case (b.operation)
      OP_READ: begin
        case (b.reg_index)
          REG_CTL: begin
            dir = ctl_word[CTL_DIR_SHIFT +: 7];
            din = (ctl_word[CTL_OUT_SHIFT +: 7] & dir) | ((io_latched | b.board_io_levels) & ~dir);
            r.read_data = ctl_word | {25'd0, din};
          end
          REG_MFDOUT: r.read_data = mf_dout;
          REG_MFDIR:  r.read_data = mf_dir;
          REG_MFDIN: begin
            outs = mf_dir & mf_sel;
            r.read_data = (mf_dout & outs) | ((mf_latched | b.board_mf_levels) & ~outs);
          end
          REG_MFSEL:  r.read_data = mf_sel;
          REG_IOPD:   r.read_data = {25'd0, io_pd};
          REG_MFPD:   r.read_data = mf_pd;
          default:    r.access_error = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (b.reg_index)
          REG_CTL: begin
            if ((b.write_data & CTL_RESERVED) != 0) begin
              r.access_error = 1'b1;
            end else begin
              ctl_word = b.write_data & CTL_WRITABLE;
              r.outputs_changed = 1'b1;
            end
          end
          REG_MFDOUT: begin
            mf_dout = b.write_data;
            r.outputs_changed = 1'b1;
          end
          REG_MFDIR: begin
            mf_dir = b.write_data;
            r.outputs_changed = 1'b1;
          end
          REG_MFSEL: begin
            mf_sel = b.write_data;
            r.outputs_changed = 1'b1;
          end
          REG_IOPD: begin
            if ((b.write_data & ~IO_MASK) != 0) r.access_error = 1'b1;
            else io_pd = b.write_data[6:0];
          end
          REG_MFPD: mf_pd = b.write_data;
          default:  r.access_error = 1'b1;
        endcase
      end
      OP_DRIVE_MF: begin
        prev = mf_latched[b.pin_number];
        mf_latched[b.pin_number] = b.pin_level;
        if (prev != b.pin_level) begin
          r.irq_valid = 1'b1;
          r.irq_group = b.pin_level ? IRQ_MF_RISE : IRQ_MF_FALL;
          r.irq_bits = 32'd1 << b.pin_number;
        end
      end
      default: begin
        if (b.pin_number >= IO_PINS) begin
          r.access_error = 1'b1;
        end else begin
          prev = io_latched[b.pin_number];
          io_latched[b.pin_number] = b.pin_level;
          if (prev != b.pin_level) begin
            r.irq_valid = 1'b1;
            r.irq_group = IRQ_IO;
            r.irq_bits = b.pin_level ? (32'd1 << (IO_RISE_SHIFT + b.pin_number))
                                     : (32'd1 << b.pin_number);
          end
        end
      end
    endcase
    r.io_out_levels = ctl_word[CTL_OUT_SHIFT +: 7];
    r.io_out_enable = ctl_word[CTL_DIR_SHIFT +: 7];
    r.mf_out_levels = mf_dout;
    r.mf_out_enable = mf_dir & mf_sel;
    return r;
  endfunction

  function automatic req_t make_beat(input op_t op, input reg_idx_t idx, input logic [31:0] data,
                                     input logic [4:0] pin, input logic lvl,
                                     input logic [6:0] bio, input logic [31:0] bmf);
    req_t b;
    b.operation = op;
    b.reg_index = idx;
    b.write_data = data;
    b.pin_number = pin;
    b.pin_level = lvl;
    b.board_io_levels = bio;
    b.board_mf_levels = bmf;
    return b;
  endfunction

  function automatic req_t random_beat();
    req_t b;
    b.operation = op_t'($urandom_range(0, 3));
    b.reg_index = ($urandom_range(0, 15) == 0) ? REG_INVALID : reg_idx_t'($urandom_range(0, 6));
    b.write_data = $urandom;
    b.pin_number = 5'($urandom_range(0, 31));
    b.pin_level = 1'($urandom_range(0, 1));
    b.board_io_levels = 7'($urandom_range(0, 127));
    b.board_mf_levels = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    if ($urandom_range(0, 15) == 0) b.write_data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    if (b.operation == OP_WRITE && $urandom_range(0, 7) != 0) begin
      if (b.reg_index == REG_CTL) b.write_data &= CTL_WRITABLE | IO_MASK;
      else if (b.reg_index == REG_IOPD) b.write_data &= IO_MASK;
    end
    if (b.operation == OP_DRIVE_IO && $urandom_range(0, 7) != 0)
      b.pin_number = 5'($urandom_range(0, IO_PINS - 1));
    return b;
  endfunction

  task automatic send_beat(input req_t b);
    rsp_t want;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.operation       <= b.operation;
    req_ch.reg_index       <= b.reg_index;
    req_ch.write_data      <= b.write_data;
    req_ch.pin_number      <= b.pin_number;
    req_ch.pin_level       <= b.pin_level;
    req_ch.board_io_levels <= b.board_io_levels;
    req_ch.board_mf_levels <= b.board_mf_levels;
    do @(posedge clk); while (!req_ch.ready);
    want = gpio_predict(b);
    pending_q = {pending_q, want};
    beats_sent++;
    if (want.irq_valid) irq_count++;
    if (want.access_error) error_count++;
    if (want.outputs_changed) changed_count++;
  endtask

  task automatic test_reset_values();
    send_beat(make_beat(OP_READ, REG_CTL, 32'd0, 5'd0, 1'b0, 7'h7F, 32'd0));
    send_beat(make_beat(OP_READ, REG_MFDIN, 32'd0, 5'd0, 1'b0, 7'h00, 32'hFFFF_FFFF));
    send_beat(make_beat(OP_READ, REG_IOPD, 32'd0, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_READ, REG_INVALID, 32'd0, 5'd0, 1'b0, 7'h00, 32'd0));
  endtask

  task automatic test_register_corners();
    send_beat(make_beat(OP_WRITE, REG_CTL, 32'hFFFF_FFFF, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_CTL, 32'h7F7F_7F7F, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_READ, REG_CTL, 32'd0, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_IOPD, 32'h0000_007F, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_IOPD, 32'h0000_0080, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_MFDIN, 32'hFFFF_FFFF, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_INVALID, 32'hFFFF_FFFF, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_MFDOUT, 32'hA5A5_5A5A, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_MFDIR, 32'hFFFF_FFFF, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_MFSEL, 32'h0000_FFFF, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_WRITE, REG_MFPD, 32'hFFFF_FFFF, 5'd0, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_READ, REG_MFDIN, 32'd0, 5'd0, 1'b0, 7'h00, 32'h0F0F_0F0F));
  endtask

  task automatic test_pin_edges();
    send_beat(make_beat(OP_DRIVE_MF, REG_CTL, 32'd0, 5'd31, 1'b1, 7'h00, 32'd0));
    send_beat(make_beat(OP_DRIVE_MF, REG_CTL, 32'd0, 5'd31, 1'b1, 7'h00, 32'd0));
    send_beat(make_beat(OP_DRIVE_MF, REG_CTL, 32'd0, 5'd31, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_DRIVE_IO, REG_CTL, 32'd0, 5'd6, 1'b1, 7'h00, 32'd0));
    send_beat(make_beat(OP_DRIVE_IO, REG_CTL, 32'd0, 5'd0, 1'b1, 7'h00, 32'd0));
    send_beat(make_beat(OP_DRIVE_IO, REG_CTL, 32'd0, 5'd6, 1'b0, 7'h00, 32'd0));
    send_beat(make_beat(OP_DRIVE_IO, REG_CTL, 32'd0, 5'd7, 1'b1, 7'h00, 32'd0));
    send_beat(make_beat(OP_DRIVE_IO, REG_CTL, 32'd0, 5'd31, 1'b1, 7'h00, 32'd0));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        src_idle_on = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      send_beat(random_beat());
    end
  endtask

  task automatic test_backpressure(input int unsigned count);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_requests++;
    for (int unsigned i = 0; i < count; i++) send_beat(random_beat());
  endtask

  task automatic test_quiet_tail(input int unsigned count);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    for (int unsigned i = 0; i < count; i++) send_beat(random_beat());
  endtask

  initial begin : rsp_ready_drive
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned stall_left;
    hold_served = 0;
    hold_left = 0;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        $display("%0t mismatch: result beat with nothing expected, actual read_data %h",
                 $time, rsp_ch.read_data);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        compare_field("read_data", want.read_data, rsp_ch.read_data);
        compare_field("access_error", 32'(want.access_error), 32'(rsp_ch.access_error));
        compare_field("irq_valid", 32'(want.irq_valid), 32'(rsp_ch.irq_valid));
        compare_field("irq_group", 32'(want.irq_group), 32'(rsp_ch.irq_group));
        compare_field("irq_bits", want.irq_bits, rsp_ch.irq_bits);
        compare_field("outputs_changed", 32'(want.outputs_changed),
                      32'(rsp_ch.outputs_changed));
        compare_field("io_out_levels", 32'(want.io_out_levels), 32'(rsp_ch.io_out_levels));
        compare_field("io_out_enable", 32'(want.io_out_enable), 32'(rsp_ch.io_out_enable));
        compare_field("mf_out_levels", want.mf_out_levels, rsp_ch.mf_out_levels);
        compare_field("mf_out_enable", want.mf_out_enable, rsp_ch.mf_out_enable);
        results_checked++;
      end
    end
  end

  initial begin : run_limit
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, pending_q.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    ctl_word = '0;
    mf_dout = '0;
    mf_dir = '0;
    mf_sel = '0;
    io_pd = '0;
    mf_pd = '0;
    mf_latched = '0;
    io_latched = '0;
    req_ch.valid           <= 1'b0;
    req_ch.operation       <= OP_READ;
    req_ch.reg_index       <= REG_CTL;
    req_ch.write_data      <= '0;
    req_ch.pin_number      <= '0;
    req_ch.pin_level       <= 1'b0;
    req_ch.board_io_levels <= '0;
    req_ch.board_mf_levels <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_register_corners();
    test_pin_edges();
    test_random_traffic(600);
    test_backpressure(40);
    test_quiet_tail(110);
    req_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("tb: %0d beats sent, %0d results checked, %0d mismatches", beats_sent,
             results_checked, fail_count);
    $display("tb: %0d edge interrupts, %0d access errors, %0d output updates", irq_count,
             error_count, changed_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/gpio_irq_pkg.sv
hdl/gpio_irq_if.sv
hdl/gpio_irq_regs.sv
hdl/gpio_port_registers_edge_irq.sv
sim/tb_gpio_port_registers_edge_irq.sv
